// ----- rtl/xgcd_pkg.sv -----
// Shared types and constants for the extended GCD core.
`default_nettype none
package xgcd_pkg;
  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_bit;
    logic update;
  } xgcd_cmd_t;

  typedef struct packed {
    logic a_zero;
  } xgcd_sts_t;
endpackage
`default_nettype wire

// ----- rtl/xgcd_datapath.sv -----
// Datapath: remainder chain, shift-subtract divider and coefficient update.
`default_nettype none
module xgcd_datapath
  import xgcd_pkg::*;
(
  input  wire logic      clk,
  input  wire xgcd_cmd_t cmd,
  input  wire word_t     in_a,
  input  wire word_t     in_b,
  output xgcd_sts_t      sts,
  output word_t          g_val,
  output word_t          u_val,
  output word_t          v_val
);
  // a = ca_a*a0 + ca_b*b0, b = cb_a*a0 + cb_b*b0
  word_t a_r, b_r, ca_a_r, ca_b_r, cb_a_r, cb_b_r;
  word_t num_r, md_r, rem_r, pa_r, pb_r;
  logic  negq_r, negn_r;

  logic [DATA_WIDTH:0] rem_sh;
  logic                ge;
  word_t               rem_nxt, r_val, qa, qb;

  always_comb begin
    rem_sh  = {rem_r, num_r[DATA_WIDTH-1]};
    ge      = rem_sh >= {1'b0, md_r};
    rem_nxt = ge ? word_t'(rem_sh - {1'b0, md_r}) : rem_sh[DATA_WIDTH-1:0];
    r_val   = negn_r ? word_t'(-rem_r) : rem_r;
    qa      = negq_r ? word_t'(-pa_r) : pa_r;
    qb      = negq_r ? word_t'(-pb_r) : pb_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= in_a;
      b_r    <= in_b;
      ca_a_r <= word_t'(1);
      ca_b_r <= '0;
      cb_a_r <= '0;
      cb_b_r <= word_t'(1);
    end else if (cmd.div_init) begin
      num_r  <= b_r[DATA_WIDTH-1] ? word_t'(-b_r) : b_r;
      md_r   <= a_r[DATA_WIDTH-1] ? word_t'(-a_r) : a_r;
      rem_r  <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      negq_r <= a_r[DATA_WIDTH-1] ^ b_r[DATA_WIDTH-1];
      negn_r <= b_r[DATA_WIDTH-1];
    end else if (cmd.div_bit) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[DATA_WIDTH-2:0], 1'b0};
      pa_r  <= {pa_r[DATA_WIDTH-2:0], 1'b0} + (ge ? ca_a_r : '0);
      pb_r  <= {pb_r[DATA_WIDTH-2:0], 1'b0} + (ge ? ca_b_r : '0);
    end else if (cmd.update) begin
      a_r    <= r_val;
      b_r    <= a_r;
      ca_a_r <= cb_a_r - qa;
      ca_b_r <= cb_b_r - qb;
      cb_a_r <= ca_a_r;
      cb_b_r <= ca_b_r;
    end
  end

  assign sts.a_zero = (a_r == '0);
  assign g_val = b_r;
  assign u_val = cb_a_r;
  assign v_val = cb_b_r;
endmodule
`default_nettype wire

// ----- rtl/xgcd_ctrl.sv -----
// Controller: sequences the Euclid steps and the bit-serial division.
`default_nettype none
module xgcd_ctrl
  import xgcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire xgcd_sts_t sts,
  output xgcd_cmd_t      cmd,
  output logic           busy,
  output logic           done
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.a_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_bit = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // nothing is taken while reset is held
  assign busy = (state_r != S_IDLE) || !rst_n;
  assign done = (state_r == S_FIN);
endmodule
`default_nettype wire

// ----- rtl/extended_gcd_signed64_core.sv -----
// Top level of the signed 64-bit extended GCD core.
// An operation starts when start is high while busy is low. Each Euclid step
// runs the check, the bit-serial shift-subtract divider and the update; a
// new pair is taken only once the last result has been shown. The
// result is shown for one cycle with out_valid; the receiver cannot stall it,
// and busy stays high until that cycle is over.
`default_nettype none
module extended_gcd_signed64_core
  import xgcd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire word_t in_operand_a,
  input  wire word_t in_operand_b,
  output logic       out_valid,
  output word_t      out_gcd_value,
  output word_t      out_coeff_a,
  output word_t      out_coeff_b
);
  xgcd_cmd_t cmd;
  xgcd_sts_t sts;

  xgcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  xgcd_datapath u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .in_a  (in_operand_a),
    .in_b  (in_operand_b),
    .sts   (sts),
    .g_val (out_gcd_value),
    .u_val (out_coeff_a),
    .v_val (out_coeff_b)
  );
endmodule
`default_nettype wire

// ----- test/xgcd_scoreboard.sv -----
// Scoreboard class for the extended GCD core: predicts and checks results.
`timescale 1ns / 100ps
class xgcd_scoreboard;
  typedef struct {
    logic [63:0] gcd;
    logic [63:0] ca;
    logic [63:0] cb;
  } bezout_t;

  bezout_t pending_q[$];
  int unsigned n_errors;
  int unsigned n_checked;

  function new();
    n_errors = 0;
    n_checked = 0;
  endfunction

  // truncating divide: quotient sign from operands, remainder from dividend
  static function void trunc_div(input logic signed [63:0] n, input logic signed [63:0] d,
                                 output logic [63:0] q, output logic [63:0] r);
    logic [63:0] mn, md, qm, rm;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    qm = mn / md;
    rm = mn % md;
    q = (n[63] != d[63]) ? -qm : qm;
    r = n[63] ? -rm : rm;
  endfunction

  static function bezout_t solve_bezout(input logic [63:0] a_in, input logic [63:0] b_in);
    logic [63:0] a, b, q, r, u, v, nu;
    logic [63:0] quots[0:131];
    int steps;
    bezout_t res;
    a = a_in;
    b = b_in;
    steps = 0;
    while (a != 0 && steps < 132) begin
      trunc_div(b, a, q, r);
      quots[steps] = q;
      steps++;
      b = a;
      a = r;
    end
    u = 0;
    v = 1;
    for (int i = steps - 1; i >= 0; i--) begin
      nu = v - quots[i] * u;
      v = u;
      u = nu;
    end
    res.gcd = b;
    res.ca = u;
    res.cb = v;
    return res;
  endfunction

  function void note_operands(input logic [63:0] a, input logic [63:0] b);
    pending_q.push_back(solve_bezout(a, b));
  endfunction

  function void check_result(input logic [63:0] g, input logic [63:0] ca,
                             input logic [63:0] cb);
    bezout_t exp;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result g=%h u=%h v=%h", $time, g, ca, cb);
      n_errors++;
      return;
    end
    exp = pending_q.pop_front();
    n_checked++;
    if (g !== exp.gcd) begin
      $display("%0t: gcd_value expected %h actual %h", $time, exp.gcd, g);
      n_errors++;
    end
    if (ca !== exp.ca) begin
      $display("%0t: coeff_a expected %h actual %h", $time, exp.ca, ca);
      n_errors++;
    end
    if (cb !== exp.cb) begin
      $display("%0t: coeff_b expected %h actual %h", $time, exp.cb, cb);
      n_errors++;
    end
  endfunction
endclass

// ----- test/testbench.sv -----
// Testbench top for the extended GCD core: directed and random operand pairs.
`timescale 1ns / 100ps
module testbench;
  import xgcd_pkg::*;

  localparam int N_RANDOM   = 830;
  localparam int STALL_LIMIT = 20000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t in_operand_a = '0;
  word_t in_operand_b = '0;
  logic  out_valid;
  word_t out_gcd_value, out_coeff_a, out_coeff_b;

  xgcd_scoreboard sb;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;

  extended_gcd_signed64_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_gcd_value(out_gcd_value),
    .out_coeff_a(out_coeff_a), .out_coeff_b(out_coeff_b)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mix of full-width, small, near-extreme and power-of-two values
  function automatic logic [63:0] rand_operand();
    logic [63:0] x;
    case ($urandom_range(0, 5))
      0: x = rand64();
      1: x = 64'($signed($urandom_range(0, 40)) - 20);
      2: x = {{32{1'b0}}, $urandom()} >> $urandom_range(0, 31);
      3: x = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
      4: x = 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 3);
      default: x = 64'd1 << $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 3) == 0) x = -x;
    return x;
  endfunction

  // present one transaction and hold it until accepted
  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    @(negedge clk);
    in_operand_a <= a;
    in_operand_b <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_operands(a, b);
    n_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_gcd_value, out_coeff_a, out_coeff_b);
  end

  // watchdog: cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired after %0d sent", $time, n_sent);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [63:0] dir_a[$];
    logic [63:0] dir_b[$];
    int burst;
    sb = new();
    dir_a = '{64'd0, 64'd0, 64'd0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
              64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'd12, -64'd12, 64'd12,
              -64'd12, 64'd1, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
              64'hb7e1_5162_8aed_2a6b, 64'd89, 64'h5555_5555_5555_5555,
              64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0000, 64'd7};
    dir_b = '{64'd0, 64'd5, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
              64'd18, 64'd18, -64'd18, -64'd18, 64'h7fff_ffff_ffff_ffff, 64'd1,
              64'h8000_0000_0000_0000, 64'h9e37_79b9_7f4a_7c15, 64'd144,
              64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'd0,
              64'hffff_ffff_ffff_fff9};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);
    // Fibonacci neighbors give the longest chains
    begin
      logic [63:0] f0, f1, t;
      f0 = 1;
      f1 = 1;
      repeat (90) begin
        t = f0 + f1;
        f0 = f1;
        f1 = t;
      end
      send_pair(f0, f1);
      send_pair(-f0, f1);
    end
    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        repeat ($urandom_range(0, 1) ? $urandom_range(0, 300) : 0) @(negedge clk);
      end
      burst--;
      send_pair(($urandom_range(0, 3) == 0) ? rand64() : rand_operand(),
                ($urandom_range(0, 3) == 0) ? rand64() : rand_operand());
    end
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d operand pairs (directed extremes, zero operand, min/-1, long chains)",
             n_sent);
    $display("and checked %0d results field by field.", sb.n_checked);
    if (sb.n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/xgcd_pkg.sv
rtl/xgcd_datapath.sv
rtl/xgcd_ctrl.sv
rtl/extended_gcd_signed64_core.sv
test/xgcd_scoreboard.sv
test/testbench.sv
